[src/sfb_pkg.sv]
// Shared types and constants for the serial frame builder.
`timescale 1ns / 1ps
`default_nettype none
package sfb_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Frame constants
    localparam logic [7:0]  HDR_BYTE0 = 8'hFF;
    localparam logic [7:0]  HDR_BYTE1 = 8'h55;
    localparam logic [15:0] LEN_EXTRA = 16'd3;

    // Byte index of the last output byte for each command kind
    localparam logic [2:0] LAST_IDX_START = 3'd4;
    localparam logic [2:0] LAST_IDX_DATA  = 3'd0;
    localparam logic [2:0] LAST_IDX_END   = 3'd2;

    // Default depth of the command queue
    localparam int SFB_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_DATA  = 2'd1,
        K_END   = 2'd2
    } t_kind;

    // One classified command: kind plus up to three computed bytes
    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic nempty;
    } t_q_status;

endpackage
`default_nettype wire

[src/serial_frame_builder_core.sv]
// Top level of the serial frame builder: front end, command queue, back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | i_valid / o_stall  | i_action, i_msg_type, i_payload_len, i_data_byte
//  output  | out       | o_valid / i_stall  | o_out_byte, o_run_last, o_frame_end
//
// An input word is taken whenever the command queue has room.
// While not stalled, the back end sends one byte per cycle: a start word yields 5
// bytes, a payload word 1 and an end word 3, so payload streams at one word per cycle.
// An input word passes the queue write and then the output register before its first byte.
// Reset is synchronous, active low, and clears state, queue and output valid.
// Output stall holds the output register; input stall rises when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_builder_core #(
    parameter int QUEUE_DEPTH = sfb_pkg::SFB_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [15:0] i_payload_len,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_frame_end
);
    import sfb_pkg::*;

    logic      push;
    logic      pop;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;

    // Classify input words and keep the running sum and check
    sfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .i_msg_type   (i_msg_type),
        .i_payload_len(i_payload_len),
        .i_data_byte  (i_data_byte),
        .i_q_status   (q_status),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Decouple front and back
    sfb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_status(q_status)
    );

    // Expand commands into frame bytes
    sfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_frame_end(o_frame_end)
    );

endmodule
`default_nettype wire

[src/sfb_front.sv]
// Front end: accepts input words, updates sum and check, builds queue commands.
`timescale 1ns / 1ps
`default_nettype none
module sfb_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_action,
    input  wire logic [7:0]       i_msg_type,
    input  wire logic [15:0]      i_payload_len,
    input  wire logic [7:0]       i_data_byte,
    input  wire sfb_pkg::t_q_status i_q_status,
    output logic                  o_stall,
    output logic                  o_push,
    output sfb_pkg::t_cmd         o_cmd
);
    import sfb_pkg::*;

    logic [15:0] r_payload_sum, n_payload_sum;
    logic [7:0]  r_check, n_check;
    logic        accept;
    logic [15:0] len_field;
    logic [15:0] inv_sum;

    // Stall only when the queue has no room
    assign o_stall   = i_q_status.full;
    assign accept    = i_valid && !i_q_status.full;
    assign len_field = i_payload_len + LEN_EXTRA;
    assign inv_sum   = ~r_payload_sum;

    // Classify the word and compute its bytes and the next state
    always_comb begin
        n_payload_sum = r_payload_sum;
        n_check       = r_check;
        o_push        = 1'b0;
        o_cmd.kind    = K_DATA;
        o_cmd.b0      = i_data_byte;
        o_cmd.b1      = 8'd0;
        o_cmd.b2      = 8'd0;
        unique case (i_action)
            ACT_START: begin
                n_payload_sum = 16'd0;
                n_check       = len_field[15:8] - len_field[7:0] - i_msg_type;
                o_push        = accept;
                o_cmd.kind    = K_START;
                o_cmd.b0      = len_field[15:8];
                o_cmd.b1      = len_field[7:0];
                o_cmd.b2      = i_msg_type;
            end
            ACT_DATA: begin
                n_payload_sum = r_payload_sum + {8'd0, i_data_byte};
                n_check       = r_check - i_data_byte;
                o_push        = accept;
            end
            ACT_END: begin
                n_check    = r_check - inv_sum[15:8] - inv_sum[7:0];
                o_push     = accept;
                o_cmd.kind = K_END;
                o_cmd.b0   = inv_sum[15:8];
                o_cmd.b1   = inv_sum[7:0];
                o_cmd.b2   = n_check;
            end
            default: begin
                // unused action code: drop the word
                o_push = 1'b0;
            end
        endcase
    end

    // Hold the running sum and check, advance on accepted words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_sum <= 16'd0;
            r_check       <= 8'd0;
        end else if (o_push) begin
            r_payload_sum <= n_payload_sum;
            r_check       <= n_check;
        end
    end

endmodule
`default_nettype wire

[src/sfb_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module sfb_queue #(
    parameter int DEPTH = sfb_pkg::SFB_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sfb_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output sfb_pkg::t_cmd       o_cmd,
    output sfb_pkg::t_q_status  o_status
);
    import sfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_MAX);
    assign o_status.nempty = (r_count != '0);

    // Write the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/sfb_back.sv]
// Back end: expands queued commands into frame bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none
module sfb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfb_pkg::t_cmd     i_cmd,
    input  wire sfb_pkg::t_q_status i_q_status,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [7:0]             o_out_byte,
    output logic                   o_run_last,
    output logic                   o_frame_end
);
    import sfb_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_fend;
    logic       load;
    logic       is_last;
    logic [2:0] last_idx;
    logic [7:0] sel_byte;

    assign load = i_q_status.nempty && (!r_valid || !i_stall);

    // Select the byte at the current index of the head command
    always_comb begin
        last_idx = LAST_IDX_DATA;
        sel_byte = i_cmd.b0;
        unique case (i_cmd.kind)
            K_START: begin
                last_idx = LAST_IDX_START;
                case (r_idx)
                    3'd0:    sel_byte = HDR_BYTE0;
                    3'd1:    sel_byte = HDR_BYTE1;
                    3'd2:    sel_byte = i_cmd.b0;
                    3'd3:    sel_byte = i_cmd.b1;
                    default: sel_byte = i_cmd.b2;
                endcase
            end
            K_DATA: begin
                last_idx = LAST_IDX_DATA;
                sel_byte = i_cmd.b0;
            end
            K_END: begin
                last_idx = LAST_IDX_END;
                case (r_idx)
                    3'd0:    sel_byte = i_cmd.b0;
                    3'd1:    sel_byte = i_cmd.b1;
                    default: sel_byte = i_cmd.b2;
                endcase
            end
            default: begin
                last_idx = LAST_IDX_DATA;
                sel_byte = i_cmd.b0;
            end
        endcase
    end

    assign is_last = (r_idx == last_idx);
    assign o_pop   = load && is_last;

    // Advance the byte index, drop the head command after its last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (load) begin
            r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= is_last;
            r_fend <= is_last && (i_cmd.kind == K_END);
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_last;
    assign o_frame_end = r_fend;

endmodule
`default_nettype wire
